FILE: hdl/dhte_pkg.sv
`default_nettype none

package dhte_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 16;
    localparam int PAY_W    = 8;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    // Fixed part of the probe step
    localparam int STEP_BASE = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] RES_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] RES_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] RES_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] RES_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] RES_DELETED   = 3'd5;

    typedef logic [1:0] t_slot_state;

    localparam t_slot_state SLOT_EMPTY    = 2'd0;
    localparam t_slot_state SLOT_DELETED  = 2'd1;
    localparam t_slot_state SLOT_OCCUPIED = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic clear;   // write one empty status entry, advance sweep
        logic load;    // capture the request
        logic start;   // load home slot, step and probe counter
        logic probe;   // issue reads and evaluate probes
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;  // sweep is at the last slot
        logic done;      // probe sequence resolved, result captured
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/dhte_if.sv
`default_nettype none

interface dhte_req_if;
    logic                          valid;
    logic                          ready;
    logic [dhte_pkg::MODE_W-1:0]   mode;
    logic [dhte_pkg::KEY_W-1:0]    key;
    logic [dhte_pkg::PAY_W-1:0]    payload;

    modport source (output valid, output mode, output key, output payload, input ready);
    modport sink   (input valid, input mode, input key, input payload, output ready);
endinterface

interface dhte_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dhte_pkg::STATUS_W-1:0] status;
    logic [dhte_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/dhte_ctrl.sv
`default_nettype none

module dhte_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output dhte_pkg::t_cmd     o_cmd,
    input  wire dhte_pkg::t_sts i_sts
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH1 = 7'b0000100,
        S_HASH2 = 7'b0001000,
        S_START = 7'b0010000,
        S_PROBE = 7'b0100000,
        S_RESP  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = S_HASH1;
            end
            S_HASH1: n_state = S_HASH2;
            S_HASH2: n_state = S_START;
            S_START: n_state = S_PROBE;
            S_PROBE: begin
                if (i_sts.done) n_state = S_RESP;
            end
            S_RESP: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RESP);

    always_comb begin
        o_cmd       = '0;
        o_cmd.clear = (r_state == S_CLEAR);
        o_cmd.load  = (r_state == S_IDLE) && i_req_valid;
        o_cmd.start = (r_state == S_START);
        o_cmd.probe = (r_state == S_PROBE);
    end

endmodule

`default_nettype wire

FILE: hdl/dhte_datapath.sv
`default_nettype none

module dhte_datapath #(
    parameter int TABLE_SIZE = 11
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dhte_pkg::t_cmd                  i_cmd,
    output dhte_pkg::t_sts                       o_sts,
    input  wire logic [dhte_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [dhte_pkg::KEY_W-1:0]      i_key,
    input  wire logic [dhte_pkg::PAY_W-1:0]      i_payload,
    output logic      [dhte_pkg::STATUS_W-1:0]   o_status,
    output logic      [dhte_pkg::SLOT_W-1:0]     o_slot_index
);

    localparam int IW         = $clog2(TABLE_SIZE);
    localparam int CW         = $clog2(TABLE_SIZE + 1);
    localparam int STEP_MOD   = TABLE_SIZE - dhte_pkg::STEP_BASE;
    // Reciprocals for the two constant remainders, quotient low by at most one
    localparam logic [31:0] RECIP_HOME = 32'((64'd1 << 32) / TABLE_SIZE);
    localparam logic [31:0] RECIP_STEP = 32'((64'd1 << 32) / STEP_MOD);
    localparam logic [31:0] HOME_DIV   = 32'(TABLE_SIZE);
    localparam logic [31:0] STEP_DIV   = 32'(STEP_MOD);
    localparam logic [IW:0] SIZE_X     = (IW+1)'(TABLE_SIZE);
    localparam logic [IW:0] STEP_MOD_X = (IW+1)'(STEP_MOD);
    localparam logic [IW:0] STEP_BASE_X = (IW+1)'(dhte_pkg::STEP_BASE);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] LAST_CNT  = CW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(TABLE_SIZE);

    // Slot stores
    dhte_pkg::t_slot_state           mem_state   [TABLE_SIZE];
    logic [dhte_pkg::KEY_W-1:0]      mem_key     [TABLE_SIZE];
    logic [dhte_pkg::PAY_W-1:0]      mem_payload [TABLE_SIZE];

    // Request
    logic [dhte_pkg::MODE_W-1:0]     r_mode;
    logic [dhte_pkg::KEY_W-1:0]      r_key;
    logic [dhte_pkg::PAY_W-1:0]      r_payload;

    // Hash pipeline
    logic [dhte_pkg::KEY_W-1:0]      r_q_home;
    logic [dhte_pkg::KEY_W-1:0]      r_q_step;
    logic [IW:0]                     r_rem_home;
    logic [IW:0]                     r_rem_step;
    logic [47:0]                     w_prod_home;
    logic [47:0]                     w_prod_step;
    logic [31:0]                     w_diff_home;
    logic [31:0]                     w_diff_step;
    logic [IW:0]                     w_home;
    logic [IW:0]                     w_step;

    // Probe sequencer
    logic [IW-1:0]                   r_loc;
    logic [IW-1:0]                   r_step;
    logic [CW-1:0]                   r_cnt;
    logic                            r_pend;
    logic                            r_rd_last;
    logic [IW-1:0]                   r_eval_loc;
    dhte_pkg::t_slot_state           r_rd_state;
    logic [dhte_pkg::KEY_W-1:0]      r_rd_key;
    logic                            w_issue;
    logic [IW:0]                     w_loc_sum;
    logic [IW:0]                     w_loc_wrap;
    logic [IW-1:0]                   n_loc;

    // Clearing sweep
    logic [IW-1:0]                   r_clr_idx;

    // Evaluation
    logic                            w_occ;
    logic                            w_match;
    logic                            w_empty;
    logic                            w_resolve;
    logic                            w_done;
    logic                            w_hit;
    logic [dhte_pkg::STATUS_W-1:0]   w_res;
    logic                            w_wr_insert;
    logic                            w_wr_delete;

    logic                            w_st_we;
    logic [IW-1:0]                   w_st_waddr;
    dhte_pkg::t_slot_state           w_st_wdata;

    logic [15:0]                     w_idx_wide;
    logic [dhte_pkg::STATUS_W-1:0]   r_status;
    logic [dhte_pkg::SLOT_W-1:0]     r_slot_index;

    // ---------------- request capture and hashing ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_key     <= i_key;
            r_payload <= i_payload;
        end
    end

    assign w_prod_home = 48'(r_key) * 48'(RECIP_HOME);
    assign w_prod_step = 48'(r_key) * 48'(RECIP_STEP);
    assign w_diff_home = 32'(r_key) - 32'(r_q_home) * HOME_DIV;
    assign w_diff_step = 32'(r_key) - 32'(r_q_step) * STEP_DIV;

    always_ff @(posedge i_clk) begin
        r_q_home   <= w_prod_home[47:32];
        r_q_step   <= w_prod_step[47:32];
        r_rem_home <= w_diff_home[IW:0];
        r_rem_step <= w_diff_step[IW:0];
    end

    // Fix up the remainder that came out one divisor too high
    assign w_home = (r_rem_home >= SIZE_X) ? r_rem_home - SIZE_X : r_rem_home;
    assign w_step = STEP_BASE_X
                  + ((r_rem_step >= STEP_MOD_X) ? r_rem_step - STEP_MOD_X : r_rem_step);

    // ---------------- probe address sequence ----------------
    assign w_issue    = i_cmd.probe && (r_cnt != FULL_CNT);
    assign w_loc_sum  = {1'b0, r_loc} + {1'b0, r_step};
    assign w_loc_wrap = (w_loc_sum >= SIZE_X) ? w_loc_sum - SIZE_X : w_loc_sum;
    assign n_loc      = w_loc_wrap[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_loc  <= w_home[IW-1:0];
            r_step <= w_step[IW-1:0];
        end else if (w_issue) begin
            r_loc <= n_loc;
        end
        if (w_issue) begin
            r_eval_loc <= r_loc;
            r_rd_last  <= (r_cnt == LAST_CNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.start) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else begin
                if (w_issue) r_cnt <= r_cnt + CW'(1);
                r_pend <= w_issue;
            end
            if (i_cmd.clear) begin
                r_clr_idx <= (r_clr_idx == LAST_SLOT) ? '0 : r_clr_idx + IW'(1);
            end
        end
    end

    // ---------------- slot stores ----------------
    always_ff @(posedge i_clk) begin
        r_rd_state <= mem_state[r_loc];
        r_rd_key   <= mem_key[r_loc];
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) mem_state[w_st_waddr] <= w_st_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_insert) begin
            mem_key[r_eval_loc]     <= r_key;
            mem_payload[r_eval_loc] <= r_payload;
        end
    end

    always_comb begin
        w_st_we    = i_cmd.clear || w_wr_insert || w_wr_delete;
        w_st_waddr = i_cmd.clear ? r_clr_idx : r_eval_loc;
        w_st_wdata = dhte_pkg::SLOT_EMPTY;
        if (w_wr_insert) w_st_wdata = dhte_pkg::SLOT_OCCUPIED;
        if (w_wr_delete) w_st_wdata = dhte_pkg::SLOT_DELETED;
    end

    // ---------------- probe evaluation ----------------
    assign w_occ     = (r_rd_state == dhte_pkg::SLOT_OCCUPIED);
    assign w_empty   = (r_rd_state == dhte_pkg::SLOT_EMPTY);
    assign w_match   = w_occ && (r_rd_key == r_key);
    assign w_resolve = i_cmd.probe && r_pend;

    always_comb begin
        w_done      = 1'b0;
        w_hit       = 1'b0;
        w_res       = dhte_pkg::RES_NOT_FOUND;
        w_wr_insert = 1'b0;
        w_wr_delete = 1'b0;
        case (r_mode)
            dhte_pkg::MODE_INSERT: begin
                if (!w_occ) begin
                    w_done      = 1'b1;
                    w_hit       = 1'b1;
                    w_res       = dhte_pkg::RES_INSERTED;
                    w_wr_insert = w_resolve;
                end else if (w_match) begin
                    w_done = 1'b1;
                    w_res  = dhte_pkg::RES_DUPLICATE;
                end else if (r_rd_last) begin
                    w_done = 1'b1;
                    w_res  = dhte_pkg::RES_FULL;
                end
            end
            dhte_pkg::MODE_SEARCH: begin
                if (w_empty) begin
                    w_done = 1'b1;
                end else if (w_match) begin
                    w_done = 1'b1;
                    w_hit  = 1'b1;
                    w_res  = dhte_pkg::RES_FOUND;
                end else if (r_rd_last) begin
                    w_done = 1'b1;
                end
            end
            dhte_pkg::MODE_DELETE: begin
                if (w_empty) begin
                    w_done = 1'b1;
                end else if (w_match) begin
                    w_done      = 1'b1;
                    w_hit       = 1'b1;
                    w_res       = dhte_pkg::RES_DELETED;
                    w_wr_delete = w_resolve;
                end else if (r_rd_last) begin
                    w_done = 1'b1;
                end
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
        w_done = w_done && w_resolve;
    end

    assign w_idx_wide = w_hit ? 16'(r_eval_loc) : 16'd0;

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_status     <= w_res;
            r_slot_index <= w_idx_wide[dhte_pkg::SLOT_W-1:0];
        end
    end

    assign o_sts.clr_last = i_cmd.clear && (r_clr_idx == LAST_SLOT);
    assign o_sts.done     = w_done;
    assign o_status       = r_status;
    assign o_slot_index   = r_slot_index;

endmodule

`default_nettype wire

FILE: hdl/double_hash_table_engine.sv
// Channel | Dir | Fields                   | Meaning
// i_req   | in  | mode, key, payload       | insert, search or delete request
// o_rsp   | out | status, slot_index       | one result per request
//
// After reset the slot status store is swept to empty, one slot per cycle,
// with i_req.ready low until the sweep reaches the last slot.
// A request goes from accept to the next ready through home/step hashing in
// S_HASH1, S_HASH2 and S_START, then one status/key memory read per probe
// (1 to TABLE_SIZE probes), then the evaluation and the result.
// One request is in flight at a time; the result holds until o_rsp.ready.
`default_nettype none

module double_hash_table_engine #(
    parameter int TABLE_SIZE = 11
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dhte_req_if.sink   i_req,
    dhte_rsp_if.source o_rsp
);

    dhte_pkg::t_cmd w_cmd;
    dhte_pkg::t_sts w_sts;

    dhte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    dhte_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_mode       (i_req.mode),
        .i_key        (i_req.key),
        .i_payload    (i_req.payload),
        .o_status     (o_rsp.status),
        .o_slot_index (o_rsp.slot_index)
    );

endmodule

`default_nettype wire

FILE: hdl/dhte_checker.sv
`default_nettype none

module dhte_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_req_valid,
    input wire logic                            i_req_ready,
    input wire logic                            i_rsp_valid,
    input wire logic                            i_rsp_ready,
    input wire logic [dhte_pkg::STATUS_W-1:0]   i_status,
    input wire logic [dhte_pkg::SLOT_W-1:0]     i_slot_index
);

    // One request in flight: no accept while a result waits
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request accepted while a result is pending");

    // Hashing states lie between accept and result, so no result right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_rsp_valid)
        else $error("result shown the cycle after accept");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status <= dhte_pkg::RES_DELETED))
        else $error("status code out of range");

    a_index_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status == dhte_pkg::RES_DUPLICATE
                         || i_status == dhte_pkg::RES_FULL
                         || i_status == dhte_pkg::RES_NOT_FOUND)) |-> (i_slot_index == '0))
        else $error("slot index not zero on a miss");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status) && $stable(i_slot_index)))
        else $error("stalled result changed");

endmodule

bind double_hash_table_engine dhte_checker u_dhte_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_slot_index (o_rsp.slot_index)
);

`default_nettype wire
